### hw/rtl/midpoint_line_rasterizer_macros.svh
// assertion macros shared by the rasterizer modules
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside reset
`define MLR_ASSERT(label, clk, arst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define MLR_NEVER(label, clk, arst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define MLR_ASSERT(label, clk, arst_n, prop, msg)

`define MLR_NEVER(label, clk, arst_n, cond, msg)

`endif

`endif

### hw/rtl/mlr_pkg.sv
package mlr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int DEC_BITS    = COORD_BITS + 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS:0] rem_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;
	typedef logic [QPTR_BITS-1:0] qptr_t;
	typedef logic [QPTR_BITS:0] qcount_t;

	typedef struct packed {
		logic   cmd;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} line_in_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last;
	} line_out_t;

	typedef struct packed {
		logic y_major;
		logic y_down;
		logic x_down;
	} dir_t;

	// classified command handed from front to back
	typedef struct packed {
		logic   is_step;
		coord_t start_x;
		coord_t start_y;
		coord_t abs_dx;
		coord_t abs_dy;
		dir_t   dir;
	} seg_cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic     valid;
		seg_cmd_t entry;
	} queue_head_t;

endpackage

### hw/rtl/mlr_front.sv
module mlr_front (
	input  mlr_pkg::line_in_t item,
	output mlr_pkg::seg_cmd_t entry
);
	import mlr_pkg::*;

	logic x_down;
	logic y_down;
	coord_t abs_dx;
	coord_t abs_dy;

	always_comb begin
		x_down = item.end_x < item.start_x;
		y_down = item.end_y < item.start_y;
		abs_dx = x_down ? coord_t'(item.start_x - item.end_x)
		                : coord_t'(item.end_x - item.start_x);
		abs_dy = y_down ? coord_t'(item.start_y - item.end_y)
		                : coord_t'(item.end_y - item.start_y);

		entry.is_step     = item.cmd == CMD_STEP;
		entry.start_x     = item.start_x;
		entry.start_y     = item.start_y;
		entry.abs_dx      = abs_dx;
		entry.abs_dy      = abs_dy;
		// equal deltas keep x as the major axis
		entry.dir.y_major = abs_dy > abs_dx;
		entry.dir.y_down  = y_down;
		entry.dir.x_down  = x_down;
	end

endmodule

### hw/rtl/mlr_cmd_queue.sv
`include "midpoint_line_rasterizer_macros.svh"

module mlr_cmd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  mlr_pkg::seg_cmd_t    wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output mlr_pkg::queue_head_t head
);
	import mlr_pkg::*;

	seg_cmd_t mem_q [QUEUE_DEPTH];
	qptr_t wr_ptr_q;
	qptr_t rd_ptr_q;
	qcount_t count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= qptr_t'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= qptr_t'(rd_ptr_q + 1'b1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= qcount_t'(count_q + 1'b1);
				2'b01:   count_q <= qcount_t'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign full       = count_q == qcount_t'(QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

	`MLR_NEVER(a_count_bound, clk, arst_n, count_q > qcount_t'(QUEUE_DEPTH), "queue overfilled")
	`MLR_ASSERT(a_rd_not_empty, clk, arst_n, rd_en |-> count_q != '0, "read from empty queue")

endmodule

### hw/rtl/mlr_back.sv
`include "midpoint_line_rasterizer_macros.svh"

module mlr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mlr_pkg::queue_head_t head,
	output logic                 rd_en,
	output logic                 empty,
	input  logic                 pop,
	output mlr_pkg::line_out_t   pixel
);
	import mlr_pkg::*;

	logic busy_q;
	coord_t cur_x_q;
	coord_t cur_y_q;
	rem_t remaining_q;
	dec_t decision_q;
	coord_t abs_dx_q;
	coord_t abs_dy_q;
	dir_t dir_q;

	logic out_valid_q;
	line_out_t out_q;

	logic busy_d;
	coord_t cur_x_d;
	coord_t cur_y_d;
	rem_t remaining_d;
	dec_t decision_d;
	coord_t abs_dx_d;
	coord_t abs_dy_d;
	dir_t dir_d;

	logic out_room;
	logic emit;
	coord_t ld_maj;
	coord_t ld_mnr;
	coord_t st_maj;
	coord_t st_mnr;
	logic minor_step;

	function automatic coord_t step_coord(coord_t c, logic down);
		step_coord = down ? coord_t'(c - 1'b1) : coord_t'(c + 1'b1);
	endfunction

	assign out_room = !out_valid_q || pop;
	// start items and idle steps never need the output register
	assign rd_en = head.valid && (!head.entry.is_step || !busy_q || out_room);
	assign emit  = rd_en && head.entry.is_step && busy_q;

	always_comb begin
		busy_d      = busy_q;
		cur_x_d     = cur_x_q;
		cur_y_d     = cur_y_q;
		remaining_d = remaining_q;
		decision_d  = decision_q;
		abs_dx_d    = abs_dx_q;
		abs_dy_d    = abs_dy_q;
		dir_d       = dir_q;

		ld_maj = head.entry.dir.y_major ? head.entry.abs_dy : head.entry.abs_dx;
		ld_mnr = head.entry.dir.y_major ? head.entry.abs_dx : head.entry.abs_dy;
		st_maj = dir_q.y_major ? abs_dy_q : abs_dx_q;
		st_mnr = dir_q.y_major ? abs_dx_q : abs_dy_q;
		minor_step = decision_q > 0;

		priority if (rd_en && !head.entry.is_step) begin
			cur_x_d     = head.entry.start_x;
			cur_y_d     = head.entry.start_y;
			abs_dx_d    = head.entry.abs_dx;
			abs_dy_d    = head.entry.abs_dy;
			dir_d       = head.entry.dir;
			remaining_d = rem_t'(ld_maj);
			decision_d  = dec_t'((dec_t'(ld_mnr) <<< 1) - dec_t'(ld_maj));
			busy_d      = ld_maj != '0;
		end else if (emit) begin
			if (remaining_q <= rem_t'(1)) begin
				remaining_d = '0;
				busy_d      = 1'b0;
			end else begin
				remaining_d = rem_t'(remaining_q - 1'b1);
				if (dir_q.y_major) begin
					cur_y_d = step_coord(cur_y_q, dir_q.y_down);
					if (minor_step) begin
						cur_x_d = step_coord(cur_x_q, dir_q.x_down);
					end
				end else begin
					cur_x_d = step_coord(cur_x_q, dir_q.x_down);
					if (minor_step) begin
						cur_y_d = step_coord(cur_y_q, dir_q.y_down);
					end
				end
				decision_d = dec_t'(decision_q + (dec_t'(st_mnr) <<< 1)
					- (minor_step ? (dec_t'(st_maj) <<< 1) : dec_t'(0)));
			end
		end else begin
			busy_d = busy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			remaining_q <= '0;
			decision_q  <= '0;
			abs_dx_q    <= '0;
			abs_dy_q    <= '0;
			dir_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q      <= busy_d;
			cur_x_q     <= cur_x_d;
			cur_y_q     <= cur_y_d;
			remaining_q <= remaining_d;
			decision_q  <= decision_d;
			abs_dx_q    <= abs_dx_d;
			abs_dy_q    <= abs_dy_d;
			dir_q       <= dir_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_x <= cur_x_q;
			out_q.pixel_y <= cur_y_q;
			out_q.last    <= remaining_q == rem_t'(1);
		end
	end

	assign empty = !out_valid_q;
	assign pixel = out_q;

	`MLR_ASSERT(a_busy_has_work, clk, arst_n, busy_q |-> remaining_q != '0, "busy with no pixels left")
	`MLR_ASSERT(a_idle_no_work, clk, arst_n, !busy_q |-> remaining_q == '0, "idle with pixels left")
	`MLR_ASSERT(a_decision_range, clk, arst_n, busy_q |-> (decision_q <= (dec_t'(st_mnr) <<< 1)) && (decision_q >= -(dec_t'(st_maj) <<< 1)), "decision term out of range")

endmodule

### hw/rtl/midpoint_line_rasterizer.sv
// channel   direction  handshake            payload
// item      in         push / full          mlr_pkg::line_in_t  (cmd, endpoints)
// pixel     out        empty / pop          mlr_pkg::line_out_t (pixel_x, pixel_y, last)
//
// one item per clock sustained while the pixel register is popped; a step item of a line
// in progress waits while it is full; steps use a single add-and-compare midpoint update
// a pixel is registered onto the result ports in the cycle after its step item is taken
// arst_n clears all control state at once; there is no clearing pass
// a four-entry command queue lets push run on while pop stalls; full rises when it fills
module midpoint_line_rasterizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mlr_pkg::line_in_t  item,
	output logic               empty,
	input  logic               pop,
	output mlr_pkg::line_out_t pixel
);
	import mlr_pkg::*;

	seg_cmd_t front_entry;
	queue_head_t head;
	logic rd_en;
	logic wr_en;

	assign wr_en = push && !full;

	mlr_front u_front (
		.item  (item),
		.entry (front_entry)
	);

	mlr_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (front_entry),
		.full    (full),
		.rd_en   (rd_en),
		.head    (head)
	);

	mlr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.rd_en  (rd_en),
		.empty  (empty),
		.pop    (pop),
		.pixel  (pixel)
	);

endmodule
